### sv/cbd_pkg.sv
// shared types, codes and result formatting for the cbor stream decoder
package cbd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } cbd_in_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  major_type;
        logic [31:0] argument;
        logic [7:0]  payload_byte;
        logic [4:0]  nest_depth;
        logic        is_key;
        logic        item_complete;
        logic        value_done;
        logic [3:0]  error_code;
    } cbd_out_t;

    // classified byte carried from the front part to the back part
    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic [2:0] major;
        logic [4:0] addl;
    } cbd_item_t;

    // result held while a run of closing containers is unwound
    typedef struct packed {
        logic [2:0]  ev;
        logic [2:0]  major;
        logic [31:0] arg;
        logic [7:0]  pay;
        logic        key;
        logic        last;
    } cbd_pend_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_EXT,
        PH_PAY,
        PH_DONE,
        PH_ERR
    } cbd_phase_t;

    typedef enum logic [1:0] {
        CTL_RUN,
        CTL_POP_RD,
        CTL_POP
    } cbd_ctl_t;

    localparam logic [2:0] EV_EXT  = 3'd0;
    localparam logic [2:0] EV_HEAD = 3'd1;
    localparam logic [2:0] EV_PAY  = 3'd2;
    localparam logic [2:0] EV_IGN  = 3'd3;
    localparam logic [2:0] EV_ERR  = 3'd4;

    localparam logic [3:0] ERR_NONE   = 4'd0;
    localparam logic [3:0] ERR_TRUNC  = 4'd1;
    localparam logic [3:0] ERR_WIDE   = 4'd2;
    localparam logic [3:0] ERR_INDEF  = 4'd3;
    localparam logic [3:0] ERR_ADDL   = 4'd4;
    localparam logic [3:0] ERR_SIMPLE = 4'd5;
    localparam logic [3:0] ERR_HUGE   = 4'd6;
    localparam logic [3:0] ERR_KEY    = 4'd7;
    localparam logic [3:0] ERR_DEEP   = 4'd8;

    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NINT   = 3'd1;
    localparam logic [2:0] MT_BYTES  = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    localparam logic [4:0] ADD_NULL    = 5'd22;
    localparam logic [4:0] ADD_ONE     = 5'd24;
    localparam logic [4:0] ADD_FOUR    = 5'd26;
    localparam logic [4:0] ADD_EIGHT   = 5'd27;
    localparam logic [4:0] ADD_INDEF   = 5'd31;

    function automatic cbd_out_t make_result(
        input logic [2:0]  ev,
        input logic [2:0]  maj,
        input logic [31:0] arg,
        input logic [7:0]  pay,
        input logic        key,
        input logic        item,
        input logic        done,
        input logic [4:0]  depth,
        input logic [3:0]  err
    );
        cbd_out_t r;
        r = '0;
        r.event_res  = ev;
        r.nest_depth = depth;
        if (ev == EV_ERR)
        begin
            r.error_code = err;
        end
        else if (ev != EV_IGN)
        begin
            r.major_type    = maj;
            r.argument      = arg;
            r.payload_byte  = pay;
            r.is_key        = key;
            r.item_complete = item;
            r.value_done    = done;
        end
        return r;
    endfunction

endpackage

### sv/cbd_front.sv
// front part: byte classification and two-entry queue towards the back part
module cbd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cbd_pkg::cbd_in_t   in_data,
    output logic               q_valid,
    input  logic               q_ready,
    output cbd_pkg::cbd_item_t q_item
);

    cbd_pkg::cbd_item_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cbd_pkg::cbd_item_t cls;

    always_comb
    begin
        cls.byte_val = in_data.in_byte;
        cls.last     = in_data.buffer_end;
        cls.major    = in_data.in_byte[7:5];
        cls.addl     = in_data.in_byte[4:0];
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### sv/cbd_back.sv
// back part: head decode, nesting stack and output register
module cbd_back #(
    parameter int MAX_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  cbd_pkg::cbd_item_t q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cbd_pkg::cbd_out_t  out_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [32:0] mem [MAX_DEPTH];

    cbd_pkg::cbd_phase_t phase_reg, phase_next;
    cbd_pkg::cbd_ctl_t   ctl_reg, ctl_next;
    logic [2:0]  major_reg, major_next;
    logic [31:0] arg_reg, arg_next;
    logic [31:0] left_reg, left_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic        top_map_reg, top_map_next;
    logic [31:0] top_cnt_reg, top_cnt_next;
    logic [3:0]  err_reg, err_next;
    cbd_pkg::cbd_pend_t pend_reg, pend_next;
    logic [32:0] rd_data_reg;
    logic        out_valid_reg, out_valid_next;
    cbd_pkg::cbd_out_t out_data_reg;

    logic        out_free, take, rd_en, mem_we, out_load;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] dm1;
    logic [32:0] mem_wdata;
    cbd_pkg::cbd_out_t res;

    logic [2:0]  ev, maj;
    logic [4:0]  add;
    logic [7:0]  pay;
    logic [31:0] a;
    logic        k, k_top, hd, cmp, casc, done;
    logic        fin, f_key, f_done, f_last;
    logic [2:0]  f_ev, f_maj;
    logic [31:0] f_arg;
    logic [7:0]  f_pay;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_ready   = (ctl_reg == cbd_pkg::CTL_RUN) && out_free;
    assign take      = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign dm1       = depth_reg - DW'(1);
    assign mem_addr  = dm1[AW-1:0];
    assign k_top     = (depth_reg != '0) && top_map_reg && !top_cnt_reg[0];

    always_comb
    begin
        phase_next   = phase_reg;
        ctl_next     = ctl_reg;
        major_next   = major_reg;
        arg_next     = arg_reg;
        left_next    = left_reg;
        depth_next   = depth_reg;
        top_map_next = top_map_reg;
        top_cnt_next = top_cnt_reg;
        err_next     = err_reg;
        pend_next    = pend_reg;
        rd_en        = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = {top_map_reg, top_cnt_reg};
        out_load     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        res          = '0;
        ev = cbd_pkg::EV_IGN;
        maj = q_item.major;
        add = q_item.addl;
        pay = 8'd0;
        a = 32'd0;
        k = 1'b0;
        hd = 1'b0;
        cmp = 1'b0;
        casc = 1'b0;
        done = 1'b0;
        fin = 1'b0;
        f_ev = cbd_pkg::EV_IGN;
        f_maj = 3'd0;
        f_arg = 32'd0;
        f_pay = 8'd0;
        f_key = 1'b0;
        f_done = 1'b0;
        f_last = 1'b0;

        unique case (ctl_reg)
            cbd_pkg::CTL_RUN:
            begin
                if (take)
                begin
                    unique case (phase_reg)
                        cbd_pkg::PH_HEAD:
                        begin
                            k = k_top;
                            major_next = maj;
                            arg_next = 32'd0;
                            left_next = 32'd0;
                            priority if (k && maj > cbd_pkg::MT_TEXT)
                            begin
                                ev = cbd_pkg::EV_ERR;
                                err_next = cbd_pkg::ERR_KEY;
                                phase_next = cbd_pkg::PH_ERR;
                            end
                            else if (maj == cbd_pkg::MT_SIMPLE)
                            begin
                                if (add == cbd_pkg::ADD_NULL)
                                begin
                                    ev = cbd_pkg::EV_HEAD;
                                    cmp = 1'b1;
                                end
                                else if (add == cbd_pkg::ADD_FOUR || add == cbd_pkg::ADD_EIGHT)
                                begin
                                    ev = cbd_pkg::EV_HEAD;
                                    left_next = (add == cbd_pkg::ADD_FOUR) ? 32'd4 : 32'd8;
                                    arg_next = left_next;
                                    phase_next = cbd_pkg::PH_PAY;
                                end
                                else
                                begin
                                    ev = cbd_pkg::EV_ERR;
                                    err_next = cbd_pkg::ERR_SIMPLE;
                                    phase_next = cbd_pkg::PH_ERR;
                                end
                            end
                            else if (add < cbd_pkg::ADD_ONE)
                            begin
                                arg_next = 32'(add);
                                a = 32'(add);
                                ev = cbd_pkg::EV_HEAD;
                                hd = 1'b1;
                            end
                            else if (add <= cbd_pkg::ADD_FOUR)
                            begin
                                left_next = 32'd1 << (add - cbd_pkg::ADD_ONE);
                                ev = cbd_pkg::EV_EXT;
                                phase_next = cbd_pkg::PH_EXT;
                            end
                            else
                            begin
                                ev = cbd_pkg::EV_ERR;
                                phase_next = cbd_pkg::PH_ERR;
                                if (add == cbd_pkg::ADD_EIGHT)
                                    err_next = cbd_pkg::ERR_WIDE;
                                else if (add == cbd_pkg::ADD_INDEF)
                                    err_next = cbd_pkg::ERR_INDEF;
                                else
                                    err_next = cbd_pkg::ERR_ADDL;
                            end
                        end
                        cbd_pkg::PH_EXT:
                        begin
                            k = k_top;
                            arg_next = {arg_reg[23:0], q_item.byte_val};
                            left_next = left_reg - 32'd1;
                            if (left_next == 32'd0)
                            begin
                                ev = cbd_pkg::EV_HEAD;
                                hd = 1'b1;
                                a = arg_next;
                            end
                            else
                            begin
                                ev = cbd_pkg::EV_EXT;
                            end
                        end
                        cbd_pkg::PH_PAY:
                        begin
                            k = k_top;
                            ev = cbd_pkg::EV_PAY;
                            pay = q_item.byte_val;
                            left_next = left_reg - 32'd1;
                            if (left_next == 32'd0)
                                cmp = 1'b1;
                        end
                        cbd_pkg::PH_ERR:
                        begin
                            ev = cbd_pkg::EV_ERR;
                        end
                        default:
                        begin
                            ev = cbd_pkg::EV_IGN;
                        end
                    endcase

                    if (hd)
                    begin
                        phase_next = cbd_pkg::PH_HEAD;
                        unique case (major_next)
                            cbd_pkg::MT_UINT, cbd_pkg::MT_NINT:
                            begin
                                cmp = 1'b1;
                            end
                            cbd_pkg::MT_BYTES, cbd_pkg::MT_TEXT:
                            begin
                                priority if (a[31])
                                begin
                                    ev = cbd_pkg::EV_ERR;
                                    err_next = cbd_pkg::ERR_HUGE;
                                    phase_next = cbd_pkg::PH_ERR;
                                end
                                else if (a == 32'd0)
                                    cmp = 1'b1;
                                else
                                begin
                                    left_next = a;
                                    phase_next = cbd_pkg::PH_PAY;
                                end
                            end
                            cbd_pkg::MT_ARRAY, cbd_pkg::MT_MAP:
                            begin
                                priority if (a[31])
                                begin
                                    ev = cbd_pkg::EV_ERR;
                                    err_next = cbd_pkg::ERR_HUGE;
                                    phase_next = cbd_pkg::PH_ERR;
                                end
                                else if (a == 32'd0)
                                    cmp = 1'b1;
                                else if (depth_reg >= DW'(MAX_DEPTH))
                                begin
                                    ev = cbd_pkg::EV_ERR;
                                    err_next = cbd_pkg::ERR_DEEP;
                                    phase_next = cbd_pkg::PH_ERR;
                                end
                                else
                                begin
                                    mem_we = (depth_reg != '0);
                                    top_map_next = (major_next == cbd_pkg::MT_MAP);
                                    top_cnt_next = (major_next == cbd_pkg::MT_MAP) ?
                                                   {a[30:0], 1'b0} : a;
                                    depth_next = depth_reg + DW'(1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    if (cmp)
                    begin
                        phase_next = cbd_pkg::PH_HEAD;
                        if (depth_reg == '0)
                            done = 1'b1;
                        else if (top_cnt_reg != 32'd1)
                            top_cnt_next = top_cnt_reg - 32'd1;
                        else
                        begin
                            depth_next = dm1;
                            if (depth_reg == DW'(1))
                                done = 1'b1;
                            else
                                casc = 1'b1;
                        end
                    end

                    if (casc)
                    begin
                        pend_next = '{ev: ev, major: major_next, arg: arg_next, pay: pay,
                                      key: k, last: q_item.last};
                        ctl_next = cbd_pkg::CTL_POP_RD;
                    end
                    else
                    begin
                        fin = 1'b1;
                        f_ev = ev;
                        f_maj = major_next;
                        f_arg = arg_next;
                        f_pay = pay;
                        f_key = k;
                        f_done = done;
                        f_last = q_item.last;
                    end
                end
            end
            cbd_pkg::CTL_POP_RD:
            begin
                rd_en = 1'b1;
                ctl_next = cbd_pkg::CTL_POP;
            end
            cbd_pkg::CTL_POP:
            begin
                if (out_free)
                begin
                    if (rd_data_reg[31:0] != 32'd1)
                    begin
                        top_map_next = rd_data_reg[32];
                        top_cnt_next = rd_data_reg[31:0] - 32'd1;
                        fin = 1'b1;
                    end
                    else
                    begin
                        depth_next = dm1;
                        if (depth_reg == DW'(1))
                        begin
                            done = 1'b1;
                            fin = 1'b1;
                        end
                        else
                            ctl_next = cbd_pkg::CTL_POP_RD;
                    end
                    if (fin)
                    begin
                        ctl_next = cbd_pkg::CTL_RUN;
                        f_ev = pend_reg.ev;
                        f_maj = pend_reg.major;
                        f_arg = pend_reg.arg;
                        f_pay = pend_reg.pay;
                        f_key = pend_reg.key;
                        f_done = done;
                        f_last = pend_reg.last;
                    end
                end
            end
            default:
            begin
                ctl_next = cbd_pkg::CTL_RUN;
            end
        endcase

        if (done)
        begin
            phase_next = cbd_pkg::PH_DONE;
            depth_next = '0;
        end

        if (fin)
        begin
            if (f_last && !f_done && phase_next != cbd_pkg::PH_DONE &&
                phase_next != cbd_pkg::PH_ERR)
            begin
                f_ev = cbd_pkg::EV_ERR;
                err_next = cbd_pkg::ERR_TRUNC;
                phase_next = cbd_pkg::PH_ERR;
            end
            out_load = 1'b1;
            out_valid_next = 1'b1;
            res = cbd_pkg::make_result(f_ev, f_maj, f_arg, f_pay, f_key,
                                       1'b1 & (f_ev != cbd_pkg::EV_EXT)
                                       & (cmp | (ctl_reg == cbd_pkg::CTL_POP)),
                                       f_done, 5'(depth_next), err_next);
            if (f_last)
            begin
                phase_next = cbd_pkg::PH_HEAD;
                major_next = 3'd0;
                arg_next = 32'd0;
                left_next = 32'd0;
                depth_next = '0;
                err_next = cbd_pkg::ERR_NONE;
                ctl_next = cbd_pkg::CTL_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cbd_pkg::PH_HEAD;
            ctl_reg       <= cbd_pkg::CTL_RUN;
            major_reg     <= 3'd0;
            arg_reg       <= 32'd0;
            left_reg      <= 32'd0;
            depth_reg     <= '0;
            top_map_reg   <= 1'b0;
            top_cnt_reg   <= 32'd0;
            err_reg       <= cbd_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ctl_reg       <= ctl_next;
            major_reg     <= major_next;
            arg_reg       <= arg_next;
            left_reg      <= left_next;
            depth_reg     <= depth_next;
            top_map_reg   <= top_map_next;
            top_cnt_reg   <= top_cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (out_load)
            out_data_reg <= res;
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[mem_addr];
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_DEPTH))
        else $error("nesting depth above limit");

    a_no_take_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg != cbd_pkg::CTL_RUN |-> !take)
        else $error("byte taken while unwinding containers");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.event_res == cbd_pkg::EV_ERR |->
        out_data_reg.error_code != cbd_pkg::ERR_NONE)
        else $error("error transfer without code");

    a_pop_read_first: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg == cbd_pkg::CTL_POP |-> $past(ctl_reg) == cbd_pkg::CTL_POP_RD ||
        $past(ctl_reg) == cbd_pkg::CTL_POP)
        else $error("stack pop without read");
`endif

endmodule

### sv/cbor_stream_decoder_top.sv
// top level of the cbor stream decoder
// Decodes one top-level CBOR value from a byte stream, one byte per transfer and
// one result transfer per byte. Bytes stream back to back while the result side takes
// results; a byte that closes nested arrays or maps holds the queue while the back part
// reads the nesting stack memory, a registered read (CTL_POP_RD, then CTL_POP) for every
// closed container that sits inside another one. A two-entry queue parts the input
// from the decoder and an output register parts the decoder from the result side.
// The byte flagged buffer_end rearms the decoder. MAX_DEPTH sets the nesting limit.
module cbor_stream_decoder_top #(
    parameter int MAX_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cbd_pkg::cbd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cbd_pkg::cbd_out_t out_data
);

    logic               q_valid;
    logic               q_ready;
    cbd_pkg::cbd_item_t q_item;

    cbd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    cbd_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### verif/testbench.sv
// self-checking testbench for the cbor stream decoder top level
module testbench;

    localparam int DEPTH_LIMIT = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    cbd_pkg::cbd_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    cbd_pkg::cbd_out_t out_data;

    cbor_stream_decoder_top #(.MAX_DEPTH(DEPTH_LIMIT)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // decoder state mirror
    cbd_pkg::cbd_phase_t dec_phase;
    logic [2:0]  dec_major;
    logic [31:0] dec_arg;
    logic [31:0] dec_left;
    int          dec_ptr;
    logic [32:0] dec_stack [DEPTH_LIMIT];
    logic        dec_finished;
    logic [3:0]  dec_err;
    logic [2:0]  r_ev;
    logic        r_item;
    logic        r_done;

    cbd_pkg::cbd_out_t expected_results [$];
    int  fail_count;
    int  cycle_count;
    bit  idle_on;
    int  rx_hold;
    int  hold_req;
    int  hold_ack;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void decoder_clear();
        dec_phase = cbd_pkg::PH_HEAD;
        dec_major = '0;
        dec_arg = '0;
        dec_left = '0;
        dec_ptr = 0;
        dec_finished = 1'b0;
        dec_err = cbd_pkg::ERR_NONE;
        foreach (dec_stack[i]) dec_stack[i] = '0;
    endfunction

    function automatic void raise_error(logic [3:0] code);
        dec_phase = cbd_pkg::PH_ERR;
        dec_err = code;
        r_ev = cbd_pkg::EV_ERR;
    endfunction

    function automatic logic at_key();
        if (dec_ptr == 0)
            return 1'b0;
        return dec_stack[dec_ptr-1][32] && !dec_stack[dec_ptr-1][0];
    endfunction

    function automatic void add_byte(ref logic [7:0] q [$], input logic [7:0] b);
        q.insert(q.size(), b);
    endfunction

    function automatic void finish_item();
        logic [31:0] cnt;
        r_item = 1'b1;
        dec_phase = cbd_pkg::PH_HEAD;
        while (dec_ptr > 0)
        begin
            cnt = dec_stack[dec_ptr-1][31:0] - 32'd1;
            if (cnt != 0)
            begin
                dec_stack[dec_ptr-1][31:0] = cnt;
                return;
            end
            dec_ptr--;
        end
        dec_finished = 1'b1;
        dec_phase = cbd_pkg::PH_DONE;
        r_done = 1'b1;
    endfunction

    function automatic void close_head();
        dec_phase = cbd_pkg::PH_HEAD;
        case (dec_major)
            cbd_pkg::MT_UINT, cbd_pkg::MT_NINT: finish_item();
            cbd_pkg::MT_BYTES, cbd_pkg::MT_TEXT:
            begin
                if (dec_arg[31]) raise_error(cbd_pkg::ERR_HUGE);
                else if (dec_arg == 0) finish_item();
                else
                begin
                    dec_left = dec_arg;
                    dec_phase = cbd_pkg::PH_PAY;
                end
            end
            cbd_pkg::MT_ARRAY, cbd_pkg::MT_MAP:
            begin
                if (dec_arg[31]) raise_error(cbd_pkg::ERR_HUGE);
                else if (dec_arg == 0) finish_item();
                else if (dec_ptr >= DEPTH_LIMIT) raise_error(cbd_pkg::ERR_DEEP);
                else
                begin
                    dec_stack[dec_ptr] = (dec_major == cbd_pkg::MT_MAP) ?
                        {1'b1, dec_arg[30:0], 1'b0} : {1'b0, dec_arg};
                    dec_ptr++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic cbd_pkg::cbd_out_t decode_byte(cbd_pkg::cbd_in_t it);
        logic [7:0] b;
        logic [2:0] maj;
        logic [4:0] add;
        logic [7:0] pay;
        logic       k;
        cbd_pkg::cbd_out_t r;
        b = it.in_byte;
        maj = b[7:5];
        add = b[4:0];
        pay = '0;
        k = 1'b0;
        r_ev = cbd_pkg::EV_IGN;
        r_item = 1'b0;
        r_done = 1'b0;
        case (dec_phase)
            cbd_pkg::PH_HEAD:
            begin
                k = at_key();
                dec_major = maj;
                dec_arg = '0;
                dec_left = '0;
                if (k && maj > cbd_pkg::MT_TEXT) raise_error(cbd_pkg::ERR_KEY);
                else if (maj == cbd_pkg::MT_SIMPLE)
                begin
                    if (add == cbd_pkg::ADD_NULL)
                    begin
                        r_ev = cbd_pkg::EV_HEAD;
                        finish_item();
                    end
                    else if (add == cbd_pkg::ADD_FOUR || add == cbd_pkg::ADD_EIGHT)
                    begin
                        r_ev = cbd_pkg::EV_HEAD;
                        dec_left = (add == cbd_pkg::ADD_FOUR) ? 32'd4 : 32'd8;
                        dec_arg = dec_left;
                        dec_phase = cbd_pkg::PH_PAY;
                    end
                    else raise_error(cbd_pkg::ERR_SIMPLE);
                end
                else if (add < cbd_pkg::ADD_ONE)
                begin
                    dec_arg = {27'd0, add};
                    r_ev = cbd_pkg::EV_HEAD;
                    close_head();
                end
                else if (add <= cbd_pkg::ADD_FOUR)
                begin
                    dec_left = 32'd1 << (add - cbd_pkg::ADD_ONE);
                    r_ev = cbd_pkg::EV_EXT;
                    dec_phase = cbd_pkg::PH_EXT;
                end
                else if (add == cbd_pkg::ADD_EIGHT) raise_error(cbd_pkg::ERR_WIDE);
                else if (add == cbd_pkg::ADD_INDEF) raise_error(cbd_pkg::ERR_INDEF);
                else raise_error(cbd_pkg::ERR_ADDL);
            end
            cbd_pkg::PH_EXT:
            begin
                k = at_key();
                dec_arg = {dec_arg[23:0], b};
                dec_left--;
                if (dec_left == 0)
                begin
                    r_ev = cbd_pkg::EV_HEAD;
                    close_head();
                end
                else r_ev = cbd_pkg::EV_EXT;
            end
            cbd_pkg::PH_PAY:
            begin
                k = at_key();
                r_ev = cbd_pkg::EV_PAY;
                pay = b;
                dec_left--;
                if (dec_left == 0) finish_item();
            end
            cbd_pkg::PH_ERR: r_ev = cbd_pkg::EV_ERR;
            default: r_ev = cbd_pkg::EV_IGN;
        endcase
        if (it.buffer_end && dec_phase != cbd_pkg::PH_DONE &&
            dec_phase != cbd_pkg::PH_ERR && !r_done)
            raise_error(cbd_pkg::ERR_TRUNC);
        r = '0;
        r.event_res = r_ev;
        r.nest_depth = dec_ptr[4:0];
        if (r_ev == cbd_pkg::EV_ERR) r.error_code = dec_err;
        else if (r_ev != cbd_pkg::EV_IGN)
        begin
            r.major_type = dec_major;
            r.argument = dec_arg;
            r.payload_byte = pay;
            r.is_key = k;
            r.item_complete = r_item;
            r.value_done = r_done;
        end
        if (it.buffer_end) decoder_clear();
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        cbd_pkg::cbd_in_t it;
        it.in_byte = b;
        it.buffer_end = last;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.insert(expected_results.size(), decode_byte(it));
    endtask

    task automatic send_buffer(input logic [7:0] bytes [$]);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // one well-formed value with random content; test_random may disturb it afterwards
    function automatic void build_value(ref logic [7:0] q [$], input int lvl);
        int kind;
        int n;
        logic [31:0] v;
        logic [2:0] mt;
        kind = $urandom_range(0, 9);
        if (lvl > 17) kind = 0;
        v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30);
        case (kind)
            0, 1:
            begin
                mt = kind[0] ? cbd_pkg::MT_NINT : cbd_pkg::MT_UINT;
                if (v < 24) add_byte(q, {mt, v[4:0]});
                else if (v < 256) add_byte(q, {mt, cbd_pkg::ADD_ONE});
                else add_byte(q, {mt, cbd_pkg::ADD_FOUR});
                if (v >= 256) add_byte(q, v[31:24]);
                if (v >= 256) add_byte(q, v[23:16]);
                if (v >= 256) add_byte(q, v[15:8]);
                if (v >= 24) add_byte(q, v[7:0]);
            end
            2, 3:
            begin
                mt = kind[0] ? cbd_pkg::MT_TEXT : cbd_pkg::MT_BYTES;
                n = $urandom_range(0, 6);
                if (n == 0 || $urandom_range(0, 1)) add_byte(q, {mt, 5'(n)});
                else
                begin
                    add_byte(q, {mt, 5'd25});
                    add_byte(q, 8'd0);
                    add_byte(q, 8'(n));
                end
                repeat (n) add_byte(q, 8'($urandom));
            end
            4, 8:
            begin
                n = $urandom_range(0, 3);
                add_byte(q, {cbd_pkg::MT_ARRAY, 5'(n)});
                repeat (n) build_value(q, lvl + 1);
            end
            5, 9:
            begin
                n = $urandom_range(0, 2);
                add_byte(q, {cbd_pkg::MT_MAP, 5'(n)});
                repeat (n)
                begin
                    add_byte(q, {cbd_pkg::MT_UINT, 5'($urandom_range(0, 23))});
                    build_value(q, lvl + 1);
                end
            end
            6:
            begin
                add_byte(q, {cbd_pkg::MT_TAG, 5'($urandom_range(0, 23))});
                build_value(q, lvl + 1);
            end
            default:
            begin
                n = $urandom_range(0, 2);
                add_byte(q, {cbd_pkg::MT_SIMPLE, n == 0 ? cbd_pkg::ADD_NULL :
                             n == 1 ? cbd_pkg::ADD_FOUR : cbd_pkg::ADD_EIGHT});
                repeat (n == 0 ? 0 : n == 1 ? 4 : 8) add_byte(q, 8'($urandom));
            end
        endcase
    endfunction

    task automatic test_directed();
        logic [7:0] q [$];
        q = '{8'h00}; send_buffer(q);
        q = '{8'h17}; send_buffer(q);
        q = '{8'h3b}; send_buffer(q);
        q = '{8'h3f}; send_buffer(q);
        q = '{8'h1c}; send_buffer(q);
        q = '{8'h1a, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff}; send_buffer(q);
        q = '{8'h5a, 8'h80, 8'h00, 8'h00, 8'h00}; send_buffer(q);
        q = '{8'h9a, 8'hff, 8'hff, 8'hff, 8'hff}; send_buffer(q);
        q = '{8'ha1, 8'h80, 8'h00}; send_buffer(q);
        q = '{8'ha1, 8'hd9, 8'h00}; send_buffer(q);
        q = '{8'hf5}; send_buffer(q);
        q = '{8'hf6}; send_buffer(q);
        q = '{8'hfb, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08}; send_buffer(q);
        q = '{8'hc1, 8'h62, 8'h41, 8'h42, 8'h43}; send_buffer(q);
        q = '{8'ha1, 8'h38, 8'hff, 8'h40}; send_buffer(q);
        q = '{8'h83, 8'h01, 8'h02}; send_buffer(q);
        q = {};
        repeat (17) add_byte(q, 8'h81);
        add_byte(q, 8'h00);
        send_buffer(q);
        q = {};
        repeat (16) add_byte(q, 8'h81);
        add_byte(q, 8'h00);
        send_buffer(q);
    endtask

    task automatic test_random(input int budget);
        logic [7:0] q [$];
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            q = {};
            build_value(q, 0);
            case ($urandom_range(0, 9))
                0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
                1: if (q.size() > 1) q.pop_back();
                2: repeat ($urandom_range(1, 3)) add_byte(q, 8'($urandom));
                default: ;
            endcase
            send_buffer(q);
            sent += q.size();
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        test_random(60);
    endtask

    // result check
    always @(posedge clk)
    begin
        cbd_pkg::cbd_out_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result expected none actual %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r !== out_data)
                begin
                    $display("%0t mismatch expected %p actual %p", $time, exp_r, out_data);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold <= 0;
        end
        else if (hold_req != hold_ack)
        begin
            out_ready <= 1'b0;
            rx_hold <= 300;
            hold_ack <= hold_req;
        end
        else if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            rx_hold <= $urandom_range(0, 16);
        end
        else out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int tail;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        fail_count = 0;
        cycle_count = 0;
        hold_req = 0;
        hold_ack = 0;
        idle_on = 1'b1;
        decoder_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1400);
        idle_on = 1'b0;
        test_random(300);
        in_valid <= 1'b0;
        tail = 0;
        while (expected_results.size() != 0 && tail < 100000)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
sv/cbd_pkg.sv
sv/cbd_front.sv
sv/cbd_back.sv
sv/cbor_stream_decoder_top.sv
verif/testbench.sv
